// File: rtl/wvm_pkg.sv
package wvm_pkg;

    // field widths of the word formats
    localparam int OP_W     = 2;
    localparam int VOICE_W  = 3;
    localparam int INDEX_W  = 6;
    localparam int SAMPLE_W = 12;
    localparam int PERIOD_W = 32;
    localparam int LEVEL_W  = 7;
    localparam int MIX_W    = 12;
    localparam int CFG_W    = 4;

    // step counter and position divider run on 32-bit words, one bit per cycle
    localparam int STEP_W    = 32;
    localparam int BIT_CNT_W = 5;
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = 5'd31;

    localparam logic [LEVEL_W:0]  PERCENT = 8'd100;
    localparam logic [STEP_W-1:0] MIX_MAX = 32'd4095;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_VOICE,
        ST_AVG,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_ACC
    } t_sc_state;

    typedef struct packed {
        logic clear;
        logic start;
    } t_sc_ctl;

endpackage

// File: rtl/wvm_scale.sv
module wvm_scale
    import wvm_pkg::*;
#(
    parameter int STEPS       = 64,
    parameter int MAX_VOICES  = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_sc_ctl                i_ctl,
    input  logic                   i_wr_en,
    input  logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] i_wr_voice,
    input  logic [$clog2(STEPS)-1:0]  i_wr_index,
    input  logic [SAMPLE_BITS-1:0] i_wr_sample,
    input  logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] i_rd_voice,
    input  logic [$clog2(STEPS)-1:0]  i_rd_pos,
    input  logic [LEVEL_W-1:0]     i_level,
    output logic                   o_idle,
    output logic [SAMPLE_BITS+$clog2(MAX_VOICES+1):0] o_sum
);

    localparam int POS_W  = $clog2(STEPS);
    localparam int VID_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int DEPTH  = MAX_VOICES * STEPS;
    localparam int ADR_W  = $clog2(DEPTH);
    localparam int PRD_W  = SAMPLE_BITS + LEVEL_W;
    localparam int SCL_W  = SAMPLE_BITS + 1;
    localparam int SUM_W  = SCL_W + $clog2(MAX_VOICES + 1);
    localparam int DCNT_W = $clog2(PRD_W);

    t_sc_state              r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [LEVEL_W-1:0]     r_lvl;
    logic [PRD_W-1:0]       r_prod;    // dividend out, quotient in
    logic [LEVEL_W-1:0]     r_rem;
    logic [DCNT_W-1:0]      r_cnt;
    logic [SUM_W-1:0]       r_sum;

    logic [ADR_W-1:0]   w_wr_addr, w_rd_addr;
    logic               w_rd_en, w_mul, w_div, w_acc;
    logic [LEVEL_W:0]   w_trial;
    logic               w_q;

    assign w_wr_addr = ADR_W'(i_wr_voice) * ADR_W'(STEPS) + ADR_W'(i_wr_index);
    assign w_rd_addr = ADR_W'(i_rd_voice) * ADR_W'(STEPS) + ADR_W'(i_rd_pos);

    // restoring divide by 100, one quotient bit per cycle
    assign w_trial = {r_rem, r_prod[PRD_W-1]};
    assign w_q     = (w_trial >= PERCENT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: if (i_ctl.start) n_state = SC_MUL;
            SC_MUL:  n_state = SC_DIV;
            SC_DIV:  if (r_cnt == '0) n_state = SC_ACC;
            SC_ACC:  n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_comb begin
        w_rd_en = 1'b0;
        w_mul   = 1'b0;
        w_div   = 1'b0;
        w_acc   = 1'b0;
        o_idle  = 1'b0;
        case (r_state)
            SC_IDLE: begin
                o_idle  = 1'b1;
                w_rd_en = i_ctl.start;
            end
            SC_MUL:  w_mul = 1'b1;
            SC_DIV:  w_div = 1'b1;
            SC_ACC:  w_acc = 1'b1;
            default: o_idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[w_wr_addr] <= i_wr_sample;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (w_mul) begin
                r_cnt <= DCNT_W'(PRD_W - 1);
            end else if (w_div) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_ctl.clear) begin
                r_sum <= '0;
            end else if (w_acc) begin
                r_sum <= r_sum + SUM_W'(r_prod[SCL_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_lvl <= i_level;
        end
        if (w_mul) begin
            r_prod <= PRD_W'(r_rd_data) * PRD_W'(r_lvl);
            r_rem  <= '0;
        end else if (w_div) begin
            r_prod <= {r_prod[PRD_W-2:0], w_q};
            r_rem  <= w_q ? LEVEL_W'(w_trial - PERCENT) : w_trial[LEVEL_W-1:0];
        end
    end

    assign o_sum = r_sum;

endmodule

// File: rtl/wavetable_voice_mixer_core.sv
// Wavetable voice mixer. Each voice owns a table of STEPS samples, a period and a
// level in percent. Load words (operation 0: write one sample, operation 1: set a
// voice's period and level) give no result. A tick word (operation 2) gives one
// mix word: voice 0 reads its table at t mod STEPS, every other voice i at
// floor((t*P0 mod 2^32)/Pi) mod STEPS, every sample is scaled by level/100, the
// terms are averaged over the voice count (1..MAX_VOICES, 0 counts as 1) and the
// result saturates at 4095; the 32-bit tick counter t then advances. A zero period
// acts as a quotient of all ones. Operation 3 is dropped. A tick holds off the next
// word until its mix has been loaded into the output register. The 32-bit position
// divider retires one quotient bit a cycle while a division runs and is the
// bottleneck; the t*P0 product is formed bit-serially first. Level scaling (a
// serial divide by 100) of one voice overlaps the position division of the next;
// the last voice's scaling, the averaging divide and the output load follow it.
// Table entries that were never written read as garbage.
// Words are taken one at a time; the mix sits in an output register, so the next
// word can enter while it waits. The voice count register has its own, always-ready
// channel; write it only while the mixer is idle, since the block does not enforce it.
module wavetable_voice_mixer_core
    import wvm_pkg::*;
#(
    parameter int STEPS       = 64,
    parameter int MAX_VOICES  = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [VOICE_W-1:0]  i_voice,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [LEVEL_W-1:0]  i_level,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [MIX_W-1:0]    o_mix,
    // voice count register
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int POS_W = $clog2(STEPS);
    localparam int VID_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W = $clog2(MAX_VOICES + 1);
    localparam int SCL_W = SAMPLE_BITS + 1;
    localparam int SUM_W = SCL_W + $clog2(MAX_VOICES + 1);
    localparam int AVC_W = $clog2(SUM_W);

    // ---------------------------------------------------------------- state
    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_voice_count;
    logic [STEP_W-1:0]    r_step;
    logic [PERIOD_W-1:0]  r_period [MAX_VOICES];
    logic [LEVEL_W-1:0]   r_level  [MAX_VOICES];

    // position unit: serial multiply, then serial divide per voice
    logic [STEP_W-1:0]    r_pd_num;     // shifts out MSB first
    logic [STEP_W-1:0]    r_pd_den;
    logic [STEP_W-1:0]    r_pd_rem;
    logic [STEP_W-1:0]    r_prod;       // t*P0 mod 2^32
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic                 r_pd_busy;
    logic                 r_pos_vld;    // r_pos holds a finished position
    logic [POS_W-1:0]     r_pos;        // running quotient mod STEPS
    logic [VID_W-1:0]     r_pd_voice;
    logic [CNT_W-1:0]     r_next_voice;

    // averaging divider
    logic [SUM_W-1:0]     r_av_num;     // sum out, quotient in
    logic [CNT_W-1:0]     r_av_rem;
    logic [AVC_W-1:0]     r_av_cnt;

    logic                 r_out_valid;
    logic [MIX_W-1:0]     r_mix;

    // ---------------------------------------------------------------- comb
    logic                 w_in_acc, w_tick, w_voice_ok;
    logic                 w_tbl_we, w_par_we;
    logic [VID_W-1:0]     w_wr_voice;
    logic [CNT_W-1:0]     w_nvoc;
    logic                 w_pd_bit;
    logic [STEP_W:0]      w_pd_trial;
    logic                 w_pd_q;
    logic                 w_pos_bit;
    logic [POS_W:0]       w_pos_dbl;
    logic [POS_W-1:0]     n_pos;
    logic [STEP_W-1:0]    n_prod;
    logic                 w_bit_last;
    logic                 w_pd_start, w_sc_start, w_voice_done;
    logic [CNT_W:0]       w_av_trial;
    logic                 w_av_q, w_av_last;
    logic                 w_out_free;
    logic [MIX_W-1:0]     n_mix;
    logic                 w_in_ready, w_mul_run, w_voice_run, w_avg_run, w_out_load;
    t_sc_ctl              w_sc_ctl;
    logic                 w_sc_idle;
    logic [SUM_W-1:0]     w_sum;

    assign w_in_acc   = i_in_valid && w_in_ready;
    assign w_tick     = w_in_acc && (i_operation == OP_TICK);
    assign w_voice_ok = (32'(i_voice) < 32'(MAX_VOICES));
    assign w_tbl_we   = w_in_acc && (i_operation == OP_WRITE) && w_voice_ok
                        && (32'(i_index) < 32'(STEPS));
    assign w_par_we   = w_in_acc && (i_operation == OP_SET) && w_voice_ok;
    assign w_wr_voice = VID_W'(i_voice);

    // voices mixed: 0 counts as 1, clamp at MAX_VOICES
    always_comb begin
        if (r_voice_count == '0) begin
            w_nvoc = CNT_W'(1);
        end else if (32'(r_voice_count) > 32'(MAX_VOICES)) begin
            w_nvoc = CNT_W'(MAX_VOICES);
        end else begin
            w_nvoc = CNT_W'(r_voice_count);
        end
    end

    // restoring divide step; a zero divisor yields all ones on its own
    assign w_pd_bit   = r_pd_num[STEP_W-1];
    assign w_pd_trial = {r_pd_rem, w_pd_bit};
    assign w_pd_q     = (w_pd_trial >= {1'b0, r_pd_den});

    // quotient (or t itself for voice 0) arrives MSB first: fold mod STEPS
    assign w_pos_bit = w_mul_run ? w_pd_bit : w_pd_q;
    assign w_pos_dbl = {r_pos, w_pos_bit};
    assign n_pos     = (w_pos_dbl >= (POS_W+1)'(STEPS))
                       ? POS_W'(w_pos_dbl - (POS_W+1)'(STEPS))
                       : w_pos_dbl[POS_W-1:0];

    // MSB-first shift-and-add, wraps at 32 bits
    assign n_prod = {r_prod[STEP_W-2:0], 1'b0} + (w_pd_bit ? r_period[0] : '0);

    assign w_bit_last = (r_bit_cnt == BIT_LAST);

    assign w_pd_start   = w_voice_run && !r_pd_busy && !r_pos_vld
                          && (r_next_voice < w_nvoc);
    assign w_sc_start   = w_voice_run && r_pos_vld && w_sc_idle;
    assign w_voice_done = w_voice_run && (r_next_voice == w_nvoc) && !r_pd_busy
                          && !r_pos_vld && w_sc_idle;

    assign w_av_trial = {r_av_rem, r_av_num[SUM_W-1]};
    assign w_av_q     = (w_av_trial >= {1'b0, w_nvoc});
    assign w_av_last  = (r_av_cnt == '0);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign n_mix      = (32'(r_av_num) > MIX_MAX) ? MIX_W'(MIX_MAX) : MIX_W'(r_av_num);

    // ---------------------------------------------------------------- fsm
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_tick) n_state = ST_MUL;
            ST_MUL:   if (w_bit_last) n_state = ST_VOICE;
            ST_VOICE: if (w_voice_done) n_state = ST_AVG;
            ST_AVG:   if (w_av_last) n_state = ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_mul_run   = 1'b0;
        w_voice_run = 1'b0;
        w_avg_run   = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE:  w_in_ready  = 1'b1;
            ST_MUL:   w_mul_run   = 1'b1;
            ST_VOICE: w_voice_run = 1'b1;
            ST_AVG:   w_avg_run   = 1'b1;
            ST_OUT:   w_out_load  = w_out_free;
            default:  w_in_ready  = 1'b0;
        endcase
    end

    assign w_sc_ctl.clear = w_tick;
    assign w_sc_ctl.start = w_sc_start;

    // ---------------------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_voice_count <= CFG_W'(1);
            r_step        <= '0;
            for (int i = 0; i < MAX_VOICES; i++) begin
                r_period[i] <= PERIOD_W'(1);
                r_level[i]  <= '0;
            end
            r_bit_cnt     <= '0;
            r_pd_busy     <= 1'b0;
            r_pos_vld     <= 1'b0;
            r_next_voice  <= '0;
            r_av_cnt      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_voice_count <= i_cfg_data;
            end
            if (w_tick) begin
                r_step <= r_step + 1'b1;
            end
            if (w_par_we) begin
                r_period[w_wr_voice] <= i_period;
                r_level[w_wr_voice]  <= i_level;
            end

            if (w_tick || w_pd_start) begin
                r_bit_cnt <= '0;
            end else if (w_mul_run || r_pd_busy) begin
                r_bit_cnt <= r_bit_cnt + 1'b1;
            end

            if (w_pd_start) begin
                r_pd_busy <= 1'b1;
            end else if (r_pd_busy && w_bit_last) begin
                r_pd_busy <= 1'b0;
            end

            if ((w_mul_run || r_pd_busy) && w_bit_last) begin
                r_pos_vld <= 1'b1;
            end else if (w_sc_start) begin
                r_pos_vld <= 1'b0;
            end

            if (w_tick) begin
                r_next_voice <= CNT_W'(1);
            end else if (w_pd_start) begin
                r_next_voice <= r_next_voice + 1'b1;
            end

            if (w_voice_done) begin
                r_av_cnt <= AVC_W'(SUM_W - 1);
            end else if (w_avg_run) begin
                r_av_cnt <= r_av_cnt - 1'b1;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath regs
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_pd_num <= r_step;
            r_prod   <= '0;
            r_pos    <= '0;
        end else if (w_mul_run) begin
            r_pd_num <= {r_pd_num[STEP_W-2:0], 1'b0};
            r_prod   <= n_prod;
            r_pos    <= n_pos;
            if (w_bit_last) begin
                r_pd_voice <= '0;
            end
        end else if (w_pd_start) begin
            r_pd_num   <= r_prod;
            r_pd_den   <= r_period[r_next_voice[VID_W-1:0]];
            r_pd_rem   <= '0;
            r_pos      <= '0;
            r_pd_voice <= VID_W'(r_next_voice);
        end else if (r_pd_busy) begin
            r_pd_num <= {r_pd_num[STEP_W-2:0], 1'b0};
            r_pd_rem <= w_pd_q ? STEP_W'(w_pd_trial - {1'b0, r_pd_den})
                               : w_pd_trial[STEP_W-1:0];
            r_pos    <= n_pos;
        end

        if (w_voice_done) begin
            r_av_num <= w_sum;
            r_av_rem <= '0;
        end else if (w_avg_run) begin
            r_av_num <= {r_av_num[SUM_W-2:0], w_av_q};
            r_av_rem <= w_av_q ? CNT_W'(w_av_trial - {1'b0, w_nvoc})
                               : w_av_trial[CNT_W-1:0];
        end

        if (w_out_load) begin
            r_mix <= n_mix;
        end
    end

    // table, level scaling and sum
    wvm_scale #(
        .STEPS       (STEPS),
        .MAX_VOICES  (MAX_VOICES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_sc_ctl),
        .i_wr_en     (w_tbl_we),
        .i_wr_voice  (w_wr_voice),
        .i_wr_index  (POS_W'(i_index)),
        .i_wr_sample (SAMPLE_BITS'(i_sample)),
        .i_rd_voice  (r_pd_voice),
        .i_rd_pos    (r_pos),
        .i_level     (r_level[r_pd_voice]),
        .o_idle      (w_sc_idle),
        .o_sum       (w_sum)
    );

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_mix       = r_mix;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------- checks
    a_pos_hold_vs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pos_vld && r_pd_busy))
        else $error("position divider restarted over an untaken position");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_vld |-> (32'(r_pos) < 32'(STEPS)))
        else $error("table position out of range");

    a_voice_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VOICE) |-> (r_next_voice <= w_nvoc))
        else $error("voice sequencer ran past the voice count");

    a_out_from_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("mix word raised outside the output state");

endmodule

// File: tb/tb_wavetable_voice_mixer_core.sv
`timescale 1ns / 100ps

module tb_wavetable_voice_mixer_core
    import wvm_pkg::*;
();

    localparam int NUM_VOICES = 8;
    localparam int WAVE_LEN   = 64;
    // operation 3 has no name in the package; the mixer drops it
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // covers the worst tick at eight voices, with margin for stalls
    localparam int SETTLE_CYCLES = 400;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SEG_WORDS     = 130;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    logic [OP_W-1:0]     in_op       = '0;
    logic [VOICE_W-1:0]  in_voice    = '0;
    logic [INDEX_W-1:0]  in_index    = '0;
    logic [SAMPLE_W-1:0] in_sample   = '0;
    logic [PERIOD_W-1:0] in_period   = '0;
    logic [LEVEL_W-1:0]  in_level    = '0;
    logic                out_ready   = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic [CFG_W-1:0]    cfg_data    = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [MIX_W-1:0]    o_mix;
    logic                o_cfg_ready;

    wavetable_voice_mixer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (in_op),
        .i_voice     (in_voice),
        .i_index     (in_index),
        .i_sample    (in_sample),
        .i_period    (in_period),
        .i_level     (in_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_mix       (o_mix),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Mixer state as the testbench tracks it
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0] wave_mem    [NUM_VOICES][WAVE_LEN];
    bit                  wave_loaded [NUM_VOICES][WAVE_LEN]; // never read an unwritten entry
    logic [PERIOD_W-1:0] voice_per   [NUM_VOICES];
    logic [LEVEL_W-1:0]  voice_lvl   [NUM_VOICES];
    logic [CFG_W-1:0]    voice_count;
    logic [STEP_W-1:0]   tick_count;

    logic [MIX_W-1:0]    pending_mix [$];   // mixes owed by the DUT, oldest first

    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    int words_sent    = 0;
    int mixes_checked = 0;
    int fail_count    = 0;
    int idle_cycles   = 0;

    // count of 0 mixes as one voice, anything above eight as eight
    function automatic int unsigned mixed_voices();
        if (voice_count == 0) return 1;
        if (voice_count > NUM_VOICES) return NUM_VOICES;
        return voice_count;
    endfunction

    // table position voice v reads at the current tick
    function automatic logic [INDEX_W-1:0] read_pos(input int v);
        logic [STEP_W-1:0] prod;
        logic [STEP_W-1:0] quo;
        if (v == 0) return INDEX_W'(tick_count % WAVE_LEN);
        prod = tick_count * voice_per[0];          // wraps at 32 bits
        quo  = (voice_per[v] == '0) ? '1 : prod / voice_per[v];
        return INDEX_W'(quo % WAVE_LEN);
    endfunction

    function automatic logic [MIX_W-1:0] mix_for_tick();
        int unsigned       n;
        logic [STEP_W-1:0] acc;
        logic [INDEX_W-1:0] p;
        n   = mixed_voices();
        acc = '0;
        for (int v = 0; v < n; v++) begin
            p   = read_pos(v);
            acc += (32'(wave_mem[v][p]) * 32'(voice_lvl[v])) / 32'(PERCENT);
        end
        acc = acc / n;
        return (acc > MIX_MAX) ? MIX_W'(MIX_MAX) : acc[MIX_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Result side: random backpressure, in-order compare
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_mix.size() == 0) begin
                $display("%0t: mix word %0d arrived with none expected", $time, o_mix);
                fail_count++;
            end else begin
                if (o_mix !== pending_mix[0]) begin
                    $display("%0t: mix mismatch, expected %0d actual %0d",
                             $time, pending_mix[0], o_mix);
                    fail_count++;
                end
                void'(pending_mix.pop_front());
                mixes_checked++;
            end
        end
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Word sender; valid stays high between back-to-back words
    // ---------------------------------------------------------------
    task automatic send_word(input logic [OP_W-1:0] op, input logic [VOICE_W-1:0] voice,
                             input logic [INDEX_W-1:0] index,
                             input logic [SAMPLE_W-1:0] sample,
                             input logic [PERIOD_W-1:0] period,
                             input logic [LEVEL_W-1:0] level);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_op     <= op;
        in_voice  <= voice;
        in_index  <= index;
        in_sample <= sample;
        in_period <= period;
        in_level  <= level;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        case (op)
            OP_WRITE: begin
                wave_mem[voice][index]    = sample;
                wave_loaded[voice][index] = 1'b1;
            end
            OP_SET: begin
                voice_per[voice] = period;
                voice_lvl[voice] = level;
            end
            OP_TICK: begin
                pending_mix.push_back(mix_for_tick());
                tick_count++;
            end
            default: ;   // dropped by the mixer
        endcase
    endtask

    // Tick word; first loads any table entry the tick would read that was
    // never written. loud fills those entries with full-scale samples.
    task automatic tick_word(input bit loud);
        int unsigned        n;
        logic [INDEX_W-1:0] p;
        n = mixed_voices();
        for (int v = 0; v < n; v++) begin
            p = read_pos(v);
            if (!wave_loaded[v][p])
                send_word(OP_WRITE, VOICE_W'(v), p,
                          loud ? '1 : SAMPLE_W'($urandom_range(4095)),
                          $urandom, LEVEL_W'($urandom_range(127)));
        end
        send_word(OP_TICK, VOICE_W'($urandom_range(7)), INDEX_W'($urandom_range(63)),
                  SAMPLE_W'($urandom_range(4095)), $urandom,
                  LEVEL_W'($urandom_range(127)));
    endtask

    // Pause the sender until every mix is back, then let the pipeline settle
    task automatic wait_mix_drained(input int settle);
        in_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_voice_count(input logic [CFG_W-1:0] value);
        wait_mix_drained(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        voice_count = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_word();
        int unsigned         pick;
        int unsigned         per_pick;
        logic [PERIOD_W-1:0] per;
        logic [LEVEL_W-1:0]  lvl;
        pick = $urandom_range(99);
        if (pick < 3) begin
            send_word(OP_NONE, VOICE_W'($urandom_range(7)), INDEX_W'($urandom_range(63)),
                      SAMPLE_W'($urandom_range(4095)), $urandom,
                      LEVEL_W'($urandom_range(127)));
        end else if (pick < 25) begin
            send_word(OP_WRITE, VOICE_W'($urandom_range(7)), INDEX_W'($urandom_range(63)),
                      SAMPLE_W'($urandom_range(4095)), $urandom,
                      LEVEL_W'($urandom_range(127)));
        end else if (pick < 40) begin
            // musical periods 1..80 and wide values, with zero and all-ones mixed in
            per_pick = $urandom_range(99);
            if (per_pick < 8)       per = '0;
            else if (per_pick < 16) per = '1;
            else if (per_pick < 56) per = PERIOD_W'($urandom_range(80, 1));
            else                    per = $urandom;
            lvl = ($urandom_range(99) < 85) ? LEVEL_W'($urandom_range(100))
                                            : LEVEL_W'($urandom_range(127));
            send_word(OP_SET, VOICE_W'($urandom_range(7)), INDEX_W'($urandom_range(63)),
                      SAMPLE_W'($urandom_range(4095)), per, lvl);
        end else begin
            tick_word(1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // defaults after reset: one voice, level zero, so the mix is zero; an operation 3 word between the ticks is dropped
    task automatic test_reset_state();
        tick_word(1'b0);
        send_word(OP_NONE, '1, '1, '1, '1, '1);
        tick_word(1'b0);
    endtask

    // full voice set at level 127 and full-scale samples saturates the mix;
    // periods at zero, one and all ones cover the divider corners
    task automatic test_field_extremes();
        write_voice_count(4'd8);
        send_word(OP_SET, 3'd0, '0, '0, '1, 7'd127);
        send_word(OP_SET, 3'd1, '1, '1, '0, 7'd127);
        send_word(OP_SET, 3'd2, '0, '1, 32'd1, 7'd127);
        for (int v = 3; v < NUM_VOICES; v++)
            send_word(OP_SET, VOICE_W'(v), '0, '0, $urandom, 7'd127);
        tick_word(1'b1);
        send_word(OP_SET, 3'd0, '1, '0, 32'd1, 7'd100);
        send_word(OP_WRITE, 3'd0, 6'd63, 12'd0, '0, '0);
        tick_word(1'b1);
        send_word(OP_SET, 3'd1, '0, '0, 32'd1, 7'd0);
        tick_word(1'b0);
        wait_mix_drained(1);
    endtask

    // random traffic in segments, voice count rewritten between segments
    task automatic test_random_traffic(input int s_pct, input int r_pct,
                                       input logic [CFG_W-1:0] first_count, input int n_words);
        int start;
        int seg_start;
        bit first_seg;
        send_gap_pct = s_pct;
        recv_gap_pct = r_pct;
        start        = words_sent;
        first_seg    = 1'b1;
        while (words_sent - start < n_words) begin
            write_voice_count(first_seg ? first_count : CFG_W'($urandom_range(15)));
            first_seg = 1'b0;
            seg_start = words_sent;
            while (words_sent - seg_start < SEG_WORDS && words_sent - start < n_words)
                send_random_word();
        end
    endtask

    initial begin
        tick_count  = '0;
        voice_count = CFG_W'(1);
        for (int v = 0; v < NUM_VOICES; v++) begin
            voice_per[v] = PERIOD_W'(1);
            voice_lvl[v] = '0;
            for (int s = 0; s < WAVE_LEN; s++) begin
                wave_mem[v][s]    = '0;
                wave_loaded[v][s] = 1'b0;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct = 37;
        recv_gap_pct = 45;
        test_reset_state();
        test_field_extremes();
        test_random_traffic(37, 45, 4'd0,  540);
        test_random_traffic(45, 37, 4'd15, 540);
        test_random_traffic(0,  0,  4'd1,  540);

        wait_mix_drained(SETTLE_CYCLES);

        $display("Sent %0d words and checked %0d mixes over voice counts 0..15,", words_sent,
                 mixes_checked);
        $display("three pacing modes, zero and all-ones periods and mix saturation.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
